// File: hw/rtl/fit_block_allocator_top_macros.svh
// Assertion macros for the fit block allocator.
// Used by fit_block_allocator_top; expects clk and rst_n in scope.
`ifndef FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`define FBA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fba_pkg.sv
// Shared types and constants for the fit block allocator.
// No dependencies.
package fba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W      = 8 + 2 * SIZE_BITS;
  localparam int PADDR_W    = 3;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_BLOCKS   = 1'b1;
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic [4:0] BLOCKS_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RESTORE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESTORE,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  block_index;
    logic [15:0] block_capacity;
    logic [7:0]  block_label;
    logic [15:0] request_size;
    logic        last_request;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  granted_label;
    logic [3:0]  granted_index;
    logic [15:0] space_left;
    logic        batch_end;
  } out_t;

  typedef struct packed {
    logic [7:0]           label;
    logic [SIZE_BITS-1:0] total;
    logic [SIZE_BITS-1:0] free;
  } ent_t;

endpackage

// File: hw/rtl/fit_block_allocator_top.sv
// Load writes one table entry; restore sweeps every entry of the 16-entry table.
// Allocation reads one table entry per cycle over the n blocks in use, and first fit
// stops early; a grant then passes an update step, and no blocks in use skips the scan.
// A new allocation is taken only once the last result has left the scan; a new request
// is taken while a result waits in the output stage.
// Reset (rst_n, synchronous): table reads empty, fit_policy = 0, blocks_in_use = 16.
`include "fit_block_allocator_top_macros.svh"
module fit_block_allocator_top import fba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       policy_r, policy_nxt;
  logic [4:0] blocks_r, blocks_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;
  logic       res_valid, res_ready;
  out_t       res_data;
  logic       cfg_wr;

  fba_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_policy (policy_r),
    .cfg_blocks (blocks_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    policy_nxt = policy_r;
    blocks_nxt = blocks_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_POLICY: policy_nxt = pwdata[0];
        REG_BLOCKS: blocks_nxt = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = {31'b0, policy_r};
      REG_BLOCKS: prdata = {27'b0, blocks_r};
      default:    prdata = '0;
    endcase
  end

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_FIRST;
      blocks_r    <= BLOCKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      policy_r    <= policy_nxt;
      blocks_r    <= blocks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FBA_ASSERT_NEXT(a_res_lands, res_valid && res_ready, out_valid_r, "result lost into output stage")
  `FBA_ASSERT_IMPLIES(a_busy_excl, res_valid, !in_ready, "request taken while result pending")
  `FBA_ASSERT_IMPLIES(a_nofit_zero, out_valid_r && !out_data_r.found, out_data_r.granted_label == '0 && out_data_r.granted_index == '0 && out_data_r.space_left == '0, "no-fit result not cleared")

endmodule

// File: hw/rtl/fba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/fba_scan.sv
// Block table sequencer: load, restore sweep and first/best fit scan.
// Depends on fba_pkg and fba_ram.
module fba_scan import fba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  input  logic       cfg_policy,
  input  logic [4:0] cfg_blocks,
  output logic       res_valid,
  input  logic       res_ready,
  output out_t       res_data
);

  scan_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;
  logic                   last_r, last_nxt;
  logic                   have_r, have_nxt;
  logic [IDX_W-1:0]       pick_idx_r, pick_idx_nxt;
  ent_t                   pick_ent_r, pick_ent_nxt;
  logic [MAX_BLOCKS-1:0]  valid_r, valid_nxt;
  out_t                   res_r, res_nxt;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  ent_t                   ram_wdata, rd_ent, cur_ent;
  logic [ENT_W-1:0]       ram_rdata;
  logic                   fits, better, last_cmp;
  logic [SIZE_BITS-1:0]   new_free, in_cap;
  logic [CNT_W-1:0]       n_sat;

  fba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent   = ent_t'(ram_rdata);
  assign cur_ent  = valid_r[cmp_idx_r] ? rd_ent : '0;
  assign fits     = cur_ent.free >= req_r;
  assign better   = !have_r || (cur_ent.free < pick_ent_r.free);
  assign last_cmp = CNT_W'(cmp_idx_r) == (n_r - CNT_W'(1));
  assign new_free = pick_ent_r.free - req_r;
  assign in_cap   = SIZE_BITS'(in_data.block_capacity);
  assign n_sat    = (int'(cfg_blocks) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cfg_blocks);

  assign in_ready  = state_r == ST_IDLE;
  assign res_valid = state_r == ST_DONE;
  assign res_data  = res_r;

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    n_nxt        = n_r;
    req_nxt      = req_r;
    last_nxt     = last_r;
    have_nxt     = have_r;
    pick_idx_nxt = pick_idx_r;
    pick_ent_nxt = pick_ent_r;
    valid_nxt    = valid_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_LOAD: begin
              if (int'(in_data.block_index) < MAX_BLOCKS) begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(in_data.block_index);
                ram_wdata = '{label: in_data.block_label, total: in_cap, free: in_cap};
                valid_nxt[IDX_W'(in_data.block_index)] = 1'b1;
              end
            end
            OP_ALLOC: begin
              req_nxt  = SIZE_BITS'(in_data.request_size);
              last_nxt = in_data.last_request;
              have_nxt = 1'b0;
              n_nxt    = n_sat;
              if (n_sat == '0) begin
                res_nxt   = '{found: 1'b0, granted_label: '0, granted_index: '0,
                              space_left: '0, batch_end: in_data.last_request};
                state_nxt = ST_DONE;
              end else begin
                ram_re      = 1'b1;
                rd_idx_nxt  = CNT_W'(1);
                cmp_idx_nxt = '0;
                state_nxt   = ST_SCAN;
              end
            end
            OP_RESTORE: begin
              ram_re      = 1'b1;
              rd_idx_nxt  = CNT_W'(1);
              cmp_idx_nxt = '0;
              state_nxt   = ST_RESTORE;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < n_r) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        if (fits && (cfg_policy == POLICY_FIRST || better)) begin
          have_nxt     = 1'b1;
          pick_idx_nxt = cmp_idx_r;
          pick_ent_nxt = cur_ent;
        end
        if ((fits && cfg_policy == POLICY_FIRST) || last_cmp) begin
          if (have_nxt) begin
            state_nxt = ST_UPDATE;
          end else begin
            res_nxt   = '{found: 1'b0, granted_label: '0, granted_index: '0,
                          space_left: '0, batch_end: last_r};
            state_nxt = ST_DONE;
          end
        end
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx_r;
        ram_wdata = '{label: pick_ent_r.label, total: pick_ent_r.total, free: new_free};
        valid_nxt[pick_idx_r] = 1'b1;
        res_nxt   = '{found: 1'b1, granted_label: pick_ent_r.label,
                      granted_index: 4'(pick_idx_r), space_left: 16'(new_free),
                      batch_end: last_r};
        state_nxt = ST_DONE;
      end
      ST_RESTORE: begin
        if (rd_idx_r < CNT_W'(MAX_BLOCKS)) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (valid_r[cmp_idx_r]) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_r;
          ram_wdata = '{label: rd_ent.label, total: rd_ent.total, free: rd_ent.total};
        end
        cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        if (cmp_idx_r == IDX_W'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    n_r        <= n_nxt;
    req_r      <= req_nxt;
    last_r     <= last_nxt;
    have_r     <= have_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_ent_r <= pick_ent_nxt;
    res_r      <= res_nxt;
  end

endmodule
